FILE: rtl/sws_pkg.sv
// sws_pkg: shared types and constants of the sliding window sender
// transaction structs, controller/datapath command and status, result codes
// no dependencies
package sws_pkg;

	localparam int SEQ_W       = 4;
	localparam int CNT_W       = 24;
	localparam int KIND_W      = 3;
	localparam int ACT_W       = 2;
	localparam int LIM_W       = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 24;
	localparam int WINDOW_SIZE = 5;
	localparam int SEQ_MODULUS = 10;

	localparam logic [LIM_W-1:0] RUN_MAX     = 4'd15;
	localparam logic [LIM_W-1:0] LIMIT_RESET = 4'd15;

	// action codes
	localparam logic [ACT_W-1:0] ACT_START   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ACK     = 2'd1;
	localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_NEW    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RESEND = 3'd1;
	localparam logic [KIND_W-1:0] KIND_NONE   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DONE   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_GIVEUP = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'd1;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [SEQ_W-1:0] ack_seq;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SEQ_W-1:0]  seq;
		logic [CNT_W-1:0]  packet_index;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic pop;
		logic unmark;
		logic mark;
		logic push;
		logic resend;
		logic emit_done;
		logic emit_none;
		logic emit_giveup;
	} sws_cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             finished;
		logic             window_empty;
		logic             ack_is_head;
		logic             ack_in_range;
		logic             head_marked;
		logic             refill_ok;
		logic             last_send;
		logic             acked_done;
		logic             total_zero;
		logic             give_up;
		logic             out_free;
	} sws_stat_t;

endpackage

FILE: rtl/sliding_window_sender_unit.sv
// Sliding window sender: one transaction (start, acknowledgement or timeout) is
// taken at a time and yields one to five result transactions, the final one
// flagged by last. The controller first takes and decodes the transaction, then
// checks the window after a start, a retirement or a refill with nothing left to
// send, retires each packet that was acknowledged out of order, and then emits the
// results one by one whenever the output register is free. A new transaction is
// taken as soon as the controller is idle, even while the last result still waits
// in the output register.
// top level; depends on sws_pkg, sws_ctrl, sws_dp
module sliding_window_sender_unit #(
	parameter int WINDOW_SIZE = sws_pkg::WINDOW_SIZE,
	parameter int SEQ_MODULUS = sws_pkg::SEQ_MODULUS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [sws_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sws_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  sws_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output sws_pkg::out_item_t              out_data
);

	sws_pkg::sws_cmd_t  cmd;
	sws_pkg::sws_stat_t stat;

	sws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	sws_dp #(
		.WINDOW_SIZE (WINDOW_SIZE),
		.SEQ_MODULUS (SEQ_MODULUS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

FILE: rtl/sws_ctrl.sv
// sws_ctrl: sequencing state machine of the sliding window sender
// issues one datapath command per cycle from datapath status
// depends on sws_pkg
module sws_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  sws_pkg::sws_stat_t stat,
	output sws_pkg::sws_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_START,
		S_RETIRE,
		S_REFILL,
		S_RESEND,
		S_GIVEUP,
		S_DONE,
		S_NONE
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   in_stall_q;

	assign in_stall = in_stall_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (stat.action)
					sws_pkg::ACT_START: begin
						cmd.clear = 1'b1;
						state_nxt = S_START;
					end
					sws_pkg::ACT_ACK: begin
						if (stat.finished || stat.window_empty) begin
							state_nxt = S_NONE;
						end else if (stat.ack_is_head) begin
							cmd.pop   = 1'b1;
							state_nxt = S_RETIRE;
						end else if (stat.ack_in_range) begin
							cmd.mark  = 1'b1;
							state_nxt = S_REFILL;
						end else begin
							state_nxt = S_NONE;
						end
					end
					sws_pkg::ACT_TIMEOUT: begin
						if (stat.finished || stat.window_empty) begin
							state_nxt = S_NONE;
						end else begin
							state_nxt = S_RESEND;
						end
					end
					default: begin
						state_nxt = S_NONE;
					end
				endcase
			end
			S_START: begin
				state_nxt = stat.total_zero ? S_DONE : S_REFILL;
			end
			S_RETIRE: begin
				if (!stat.window_empty && stat.head_marked) begin
					cmd.pop    = 1'b1;
					cmd.unmark = 1'b1;
				end else if (stat.acked_done) begin
					state_nxt = S_DONE;
				end else begin
					state_nxt = S_REFILL;
				end
			end
			S_REFILL: begin
				if (!stat.refill_ok) begin
					state_nxt = S_NONE;
				end else if (stat.out_free) begin
					cmd.push = 1'b1;
					if (stat.last_send) begin
						state_nxt = S_IDLE;
					end
				end
			end
			S_RESEND: begin
				if (stat.out_free) begin
					cmd.resend = 1'b1;
					state_nxt  = stat.give_up ? S_GIVEUP : S_IDLE;
				end
			end
			S_GIVEUP: begin
				if (stat.out_free) begin
					cmd.emit_giveup = 1'b1;
					state_nxt       = S_IDLE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.emit_done = 1'b1;
					state_nxt     = S_IDLE;
				end
			end
			S_NONE: begin
				if (stat.out_free) begin
					cmd.emit_none = 1'b1;
					state_nxt     = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			in_stall_q <= (state_nxt != S_IDLE);
		end
	end

endmodule

FILE: rtl/sws_dp.sv
// sws_dp: datapath of the sliding window sender
// window, early ack map, counters, config registers and output register
// depends on sws_pkg
module sws_dp #(
	parameter int WINDOW_SIZE = sws_pkg::WINDOW_SIZE,
	parameter int SEQ_MODULUS = sws_pkg::SEQ_MODULUS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [sws_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sws_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  sws_pkg::in_item_t               in_data,
	input  sws_pkg::sws_cmd_t               cmd,
	output sws_pkg::sws_stat_t              stat,
	input  logic                            out_stall,
	output logic                            out_valid,
	output sws_pkg::out_item_t              out_data
);

	localparam int FILL_W = $clog2(WINDOW_SIZE + 1);
	localparam int SEQ_W  = sws_pkg::SEQ_W;
	localparam int CNT_W  = sws_pkg::CNT_W;
	localparam int LIM_W  = sws_pkg::LIM_W;

	logic [sws_pkg::ACT_W-1:0] action_q;
	logic [SEQ_W-1:0]          ack_q;
	logic [CNT_W-1:0]          total_q;
	logic [LIM_W-1:0]          limit_q;

	logic [SEQ_W-1:0]          seqs_q [WINDOW_SIZE];
	logic [FILL_W-1:0]         fill_q;
	logic [SEQ_MODULUS-1:0]    map_q;
	logic [SEQ_W-1:0]          next_seq_q;
	logic [CNT_W-1:0]          issued_q;
	logic [CNT_W-1:0]          acked_q;
	logic [LIM_W-1:0]          run_q;
	logic [SEQ_W-1:0]          last_resent_q;
	logic                      finished_q;

	logic                      out_valid_q;
	sws_pkg::out_item_t        out_data_q;

	logic [SEQ_W-1:0]          head;
	logic [SEQ_W-1:0]          new_seq;
	logic [SEQ_MODULUS-1:0]    head_mask;
	logic [SEQ_MODULUS-1:0]    ack_mask;
	logic [LIM_W-1:0]          run_next;
	logic                      same_seq;
	logic                      give_up;
	logic                      last_send;
	logic                      emit;
	sws_pkg::out_item_t        item;

	assign head = seqs_q[0];

	// one-hot decode of sequence numbers 1..SEQ_MODULUS onto the map
	for (genvar i = 0; i < SEQ_MODULUS; i++) begin : g_mask
		assign head_mask[i] = (head == SEQ_W'(i + 1));
		assign ack_mask[i]  = (ack_q == SEQ_W'(i + 1));
	end

	assign new_seq   = (next_seq_q == SEQ_W'(SEQ_MODULUS)) ? SEQ_W'(1)
		: next_seq_q + SEQ_W'(1);
	assign run_next  = (run_q == sws_pkg::RUN_MAX) ? run_q : run_q + LIM_W'(1);
	assign same_seq  = (last_resent_q == head);
	assign give_up   = same_seq && (run_next >= limit_q);
	assign last_send = (fill_q == FILL_W'(WINDOW_SIZE - 1))
		|| ((issued_q + CNT_W'(1)) == total_q);

	always_comb begin
		stat              = '0;
		stat.action       = action_q;
		stat.finished     = finished_q;
		stat.window_empty = (fill_q == '0);
		stat.ack_is_head  = (ack_q == head);
		stat.ack_in_range = |ack_mask;
		stat.head_marked  = |(map_q & head_mask);
		stat.refill_ok    = (fill_q < FILL_W'(WINDOW_SIZE)) && (issued_q < total_q);
		stat.last_send    = last_send;
		stat.acked_done   = (acked_q >= total_q);
		stat.total_zero   = (total_q == '0);
		stat.give_up      = give_up;
		stat.out_free     = !out_valid_q || !out_stall;
	end

	always_comb begin
		item = '0;
		item.last = 1'b1;
		if (cmd.push) begin
			item.kind         = sws_pkg::KIND_NEW;
			item.seq          = new_seq;
			item.packet_index = issued_q;
			item.last         = last_send;
		end else if (cmd.resend) begin
			item.kind         = sws_pkg::KIND_RESEND;
			item.seq          = head;
			item.packet_index = acked_q;
			item.last         = !give_up;
		end else if (cmd.emit_done) begin
			item.kind = sws_pkg::KIND_DONE;
		end else if (cmd.emit_giveup) begin
			item.kind = sws_pkg::KIND_GIVEUP;
		end else begin
			item.kind = sws_pkg::KIND_NONE;
		end
	end

	assign emit = cmd.push | cmd.resend | cmd.emit_done | cmd.emit_giveup | cmd.emit_none;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			limit_q <= sws_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				sws_pkg::REG_TOTAL: total_q <= cfg_data[CNT_W-1:0];
				sws_pkg::REG_LIMIT: limit_q <= cfg_data[LIM_W-1:0];
			endcase
		end
	end

	// latched transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= in_data.action;
			ack_q    <= in_data.ack_seq;
		end
	end

	// window entries, oldest at index 0
	for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_win
		if (i < WINDOW_SIZE - 1) begin : g_shift
			always_ff @(posedge clk) begin
				if (cmd.pop) begin
					seqs_q[i] <= seqs_q[i + 1];
				end else if (cmd.push && (fill_q == FILL_W'(i))) begin
					seqs_q[i] <= new_seq;
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk) begin
				if (cmd.push && (fill_q == FILL_W'(i))) begin
					seqs_q[i] <= new_seq;
				end
			end
		end
	end

	// transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= '0;
			map_q         <= '0;
			next_seq_q    <= '0;
			issued_q      <= '0;
			acked_q       <= '0;
			run_q         <= '0;
			last_resent_q <= '0;
			finished_q    <= 1'b0;
		end else begin
			if (cmd.clear) begin
				fill_q        <= '0;
				map_q         <= '0;
				next_seq_q    <= '0;
				issued_q      <= '0;
				acked_q       <= '0;
				run_q         <= '0;
				last_resent_q <= '0;
				finished_q    <= 1'b0;
			end
			if (cmd.pop) begin
				fill_q  <= fill_q - FILL_W'(1);
				acked_q <= acked_q + CNT_W'(1);
				if (cmd.unmark) begin
					map_q <= map_q & ~head_mask;
				end
			end
			if (cmd.mark) begin
				map_q <= map_q | ack_mask;
			end
			if (cmd.push) begin
				next_seq_q <= new_seq;
				fill_q     <= fill_q + FILL_W'(1);
				issued_q   <= issued_q + CNT_W'(1);
			end
			if (cmd.resend) begin
				run_q         <= same_seq ? run_next : '0;
				last_resent_q <= head;
			end
			if (cmd.emit_done || cmd.emit_giveup) begin
				finished_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: rtl/sws_checker.sv
// sws_checker: port-level assertions for the sliding window sender
// bound to sliding_window_sender_unit; depends on sws_pkg
module sws_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input sws_pkg::out_item_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one transaction in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a transaction is in work");

	// terminal kinds carry no packet and close the transaction
	a_terminal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.kind == sws_pkg::KIND_NONE
			|| out_data.kind == sws_pkg::KIND_DONE
			|| out_data.kind == sws_pkg::KIND_GIVEUP)
		|-> out_data.last && out_data.seq == '0 && out_data.packet_index == '0)
		else $error("terminal result malformed");

	// sent packets always carry a real sequence number
	a_sent_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.kind == sws_pkg::KIND_NEW
			|| out_data.kind == sws_pkg::KIND_RESEND)
		|-> out_data.seq != '0)
		else $error("packet sent with sequence number zero");

endmodule

bind sliding_window_sender_unit sws_checker u_sws_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

FILE: test/sliding_window_sender_unit_test.sv
// Testbench of sliding_window_sender_unit: directed and random start, ack and timeout
// transactions checked against a tracker of the window, with bursty input and stalls.
// Depends on sws_pkg and the sliding_window_sender_unit RTL.
`timescale 1ns / 100ps

module sliding_window_sender_unit_test;
	import sws_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 200;
	localparam int RANDOM_ITEMS = 340;
	localparam int TAIL_CYCLES  = 16;
	localparam int PHASE_STEPS  = 40;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic [CNT_W-1:0] TOTAL_MAX  = {CNT_W{1'b1}};

	class window_tracker;
		logic [CNT_W-1:0] total;
		logic [LIM_W-1:0] limit;
		logic [SEQ_W-1:0] window [WINDOW_SIZE];
		int               fill;
		logic [15:0]      early_map;
		logic [SEQ_W-1:0] next_seq;
		logic [CNT_W-1:0] issued;
		logic [CNT_W-1:0] acked;
		logic [LIM_W-1:0] run;
		logic [LIM_W-1:0] last_resent;
		bit               finished;
		out_item_t        awaited_sends[$];
		out_item_t        batch[$];
		int               mismatches;

		function new();
			total = '0;
			limit = LIMIT_RESET;
			mismatches = 0;
			clear_transfer();
		endfunction

		function void clear_transfer();
			foreach (window[i])
				window[i] = '0;
			fill = 0;
			early_map = '0;
			next_seq = '0;
			issued = '0;
			acked = '0;
			run = '0;
			last_resent = '0;
			finished = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_TOTAL)
				total = value[CNT_W-1:0];
			else
				limit = value[LIM_W-1:0];
		endfunction

		function void add_result(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] seq,
				logic [CNT_W-1:0] idx);
			out_item_t r;
			r.kind = kind;
			r.seq = seq;
			r.packet_index = idx;
			r.last = 1'b0;
			batch.push_back(r);
		endfunction

		function void retire_head();
			for (int i = 1; i < fill; i++)
				window[i-1] = window[i];
			if (fill > 0)
				fill--;
			acked = acked + 1'b1;
		endfunction

		function void refill();
			while (fill < WINDOW_SIZE && issued < total) begin
				next_seq = SEQ_W'((next_seq % SEQ_MODULUS) + 1);
				window[fill] = next_seq;
				fill++;
				add_result(KIND_NEW, next_seq, issued);
				issued = issued + 1'b1;
			end
		endfunction

		function void accept_command(in_item_t cmd);
			logic [SEQ_W-1:0] head;
			out_item_t r;
			batch.delete();
			if (cmd.action == ACT_START) begin
				clear_transfer();
				if (total == 0) begin
					finished = 1'b1;
					add_result(KIND_DONE, '0, '0);
				end else begin
					refill();
				end
			end else if (cmd.action == ACT_ACK && !finished && fill > 0) begin
				if (cmd.ack_seq == window[0]) begin
					retire_head();
					while (fill > 0 && early_map[window[0]]) begin
						early_map[window[0]] = 1'b0;
						retire_head();
					end
					if (acked >= total) begin
						finished = 1'b1;
						add_result(KIND_DONE, '0, '0);
					end else begin
						refill();
					end
				end else if (cmd.ack_seq >= 1 && cmd.ack_seq <= SEQ_MODULUS) begin
					early_map[cmd.ack_seq] = 1'b1;
					refill();
				end
			end else if (cmd.action == ACT_TIMEOUT && !finished && fill > 0) begin
				head = window[0];
				add_result(KIND_RESEND, head, acked);
				if (last_resent == head) begin
					if (run < RUN_MAX)
						run = run + 1'b1;
					if (run >= limit) begin
						finished = 1'b1;
						add_result(KIND_GIVEUP, '0, '0);
					end
				end else begin
					run = '0;
				end
				last_resent = head;
			end
			if (batch.size() == 0)
				add_result(KIND_NONE, '0, '0);
			r = batch.pop_back();
			r.last = 1'b1;
			batch.push_back(r);
			foreach (batch[i])
				awaited_sends.push_back(batch[i]);
		endfunction

		function void check_output(out_item_t got);
			out_item_t want;
			if (awaited_sends.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d seq %0d index %0d last %0d",
						got.kind, got.seq, got.packet_index, got.last);
			end else begin
				want = awaited_sends.pop_front();
				if (got.kind !== want.kind || got.seq !== want.seq ||
						got.packet_index !== want.packet_index || got.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected kind %0d seq %0d index %0d last %0d, %s",
							want.kind, want.seq, want.packet_index, want.last,
							$sformatf("got kind %0d seq %0d index %0d last %0d",
								got.kind, got.seq, got.packet_index, got.last));
				end
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;

	window_tracker tracker;
	bit            hold_req = 1'b0;
	int            burst_left = 0;
	int            idle_cycles = 0;

	sliding_window_sender_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #2 clk = ~clk;

	task automatic drive(in_item_t cmd);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		in_data <= cmd;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.accept_command(cmd);
		burst_left--;
	endtask

	task automatic send(logic [ACT_W-1:0] action, logic [SEQ_W-1:0] ack);
		in_item_t cmd;
		cmd.action = action;
		cmd.ack_seq = ack;
		drive(cmd);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (tracker.awaited_sends.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.write_reg(idx, value);
		@(posedge clk);
	endtask

	function automatic in_item_t pick_command(int timeout_share);
		in_item_t cmd;
		int r;
		r = $urandom_range(0, 99);
		cmd.ack_seq = SEQ_W'($urandom_range(0, 15));
		if (r < timeout_share) begin
			cmd.action = ACT_TIMEOUT;
		end else if (r < timeout_share + 50) begin
			cmd.action = ACT_ACK;
			cmd.ack_seq = tracker.window[0];
		end else if (r < timeout_share + 70) begin
			cmd.action = ACT_ACK;
			cmd.ack_seq = tracker.window[$urandom_range(0, tracker.fill - 1)];
		end else if (r < 94) begin
			cmd.action = ACT_ACK;
		end else if (r < 98) begin
			cmd.action = ACT_UNUSED;
		end else begin
			cmd.action = ACT_START;
		end
		return cmd;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				tracker.check_output(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("sliding_window_sender_unit test failed");
				$finish;
			end
		end
	end

	initial begin : stall_pattern
		int mode;
		int stretch;
		mode = 0;
		stretch = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (stretch == 0) begin
					mode = $urandom_range(0, 2);
					stretch = $urandom_range(8, 60);
				end
				stretch--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 99) < 25);
					default: out_stall <= ($urandom_range(0, 99) < 70);
				endcase
			end
		end
	end

	initial begin : stimulus
		int phase;
		int step;
		int random_items;
		int r;
		int timeout_share;
		logic [CNT_W-1:0] total_value;
		in_item_t cmd;

		tracker = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty window before any start, then a start with a total of zero
		send(ACT_ACK, 4'd1);
		send(ACT_TIMEOUT, 4'd0);
		send(ACT_UNUSED, 4'd15);
		settle();
		write_reg(REG_TOTAL, '0);
		write_reg(REG_LIMIT, CFG_DATA_W'(LIMIT_RESET));
		send(ACT_START, 4'd0);
		send(ACT_ACK, 4'd1);
		send(ACT_TIMEOUT, 4'd15);
		settle();

		// out of order acks, stale mark, resends
		write_reg(REG_TOTAL, 24'd7);
		send(ACT_START, 4'd9);
		send(ACT_ACK, 4'd0);
		send(ACT_ACK, 4'd15);
		send(ACT_ACK, 4'd3);
		send(ACT_ACK, 4'd2);
		send(ACT_ACK, 4'd1);
		send(ACT_ACK, 4'd10);
		send(ACT_TIMEOUT, 4'd0);
		send(ACT_TIMEOUT, 4'd0);
		send(ACT_ACK, 4'd4);
		send(ACT_ACK, 4'd5);
		send(ACT_ACK, 4'd7);
		send(ACT_ACK, 4'd6);
		settle();

		// give up at a limit of 1
		write_reg(REG_LIMIT, 24'd1);
		write_reg(REG_TOTAL, 24'd3);
		send(ACT_START, 4'd0);
		send(ACT_TIMEOUT, 4'd0);
		send(ACT_TIMEOUT, 4'd0);
		send(ACT_ACK, 4'd1);
		settle();

		// largest total, then lowered mid transfer
		write_reg(REG_TOTAL, TOTAL_MAX);
		write_reg(REG_LIMIT, 24'd2);
		send(ACT_START, 4'd0);
		settle();
		write_reg(REG_TOTAL, 24'd2);
		send(ACT_ACK, 4'd1);
		send(ACT_ACK, 4'd2);

		phase = 0;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			settle();
			r = $urandom_range(0, 99);
			if (phase == 2)
				total_value = 24'd20;
			else if (r < 5)
				total_value = '0;
			else if (r < 10)
				total_value = TOTAL_MAX;
			else if (r < 85)
				total_value = CNT_W'($urandom_range(1, 25));
			else
				total_value = CNT_W'($urandom_range(26, 60));
			write_reg(REG_TOTAL, total_value);
			if (phase == 0 || $urandom_range(0, 2) != 0) begin
				r = $urandom_range(0, 99);
				write_reg(REG_LIMIT,
					CFG_DATA_W'((r < 20) ? 1 : (r < 35) ? 15 : $urandom_range(1, 15)));
			end
			timeout_share = ($urandom_range(0, 3) == 0) ? 40 : 10;
			send(ACT_START, SEQ_W'($urandom_range(0, 15)));
			random_items++;
			if (phase == 2)
				hold_req = 1'b1;
			step = 0;
			while (!tracker.finished && tracker.fill > 0 && step < PHASE_STEPS &&
					random_items < RANDOM_ITEMS) begin
				if (step == 12 && $urandom_range(0, 4) == 0) begin
					settle();
					write_reg(REG_TOTAL, CFG_DATA_W'(tracker.acked + $urandom_range(0, 8)));
				end
				cmd = pick_command(timeout_share);
				drive(cmd);
				if (cmd.action != ACT_UNUSED)
					random_items++;
				step++;
			end
			phase++;
		end
		settle();

		if (tracker.mismatches == 0 && tracker.awaited_sends.size() == 0)
			$display("sliding_window_sender_unit test passed");
		else
			$display("sliding_window_sender_unit test failed");
		$finish;
	end

endmodule
